// ----- rtl/aftt_pkg.sv -----
package aftt_pkg;

   localparam int MAX_FRAMES    = 64;
   localparam int DURATION_BITS = 16;
   localparam int HANDLE_BITS   = 16;

   localparam int IDX_W     = $clog2(MAX_FRAMES);
   localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
   localparam int TIME_W    = DURATION_BITS + IDX_W;
   localparam int TIME_MS_W = 32;
   localparam int STEP_W    = $clog2(TIME_MS_W);

   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_REPLACE = 3'd3,
      OP_SWAP    = 3'd4,
      OP_LOOKUP  = 3'd5,
      OP_READ    = 3'd6,
      OP_NONE    = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [CNT_W-1:0]         position;
      logic [IDX_W-1:0]         second_position;
      logic [DURATION_BITS-1:0] duration_ms;
      logic [HANDLE_BITS-1:0]   frame_handle;
      logic [TIME_MS_W-1:0]     time_ms;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [IDX_W-1:0]         found_index;
      logic [HANDLE_BITS-1:0]   out_frame_handle;
      logic [DURATION_BITS-1:0] out_duration_ms;
      logic [TIME_W-1:0]        end_time_ms;
      logic [CNT_W-1:0]         entry_count;
      logic [TIME_W-1:0]        total_ms;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0]   handle;
      logic [DURATION_BITS-1:0] duration;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_DEL_FIN,
      S_REP_RD,
      S_REP_WR,
      S_SWP_RDA,
      S_SWP_RDB,
      S_SWP_WRA,
      S_SWP_WRB,
      S_REC_GO,
      S_REC_RD,
      S_REC_WR,
      S_DIV_GO,
      S_DIV_WAIT,
      S_SCN_RD,
      S_SCN_CMP,
      S_EMT_RD,
      S_EMT_CAP,
      S_RSP
   } state_type;

endpackage

// ----- rtl/aftt_ram.sv -----
module aftt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aftt_mod_unit.sv -----
module aftt_mod_unit
   import aftt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_MS_W-1:0] dividend,
   input  logic [TIME_W-1:0]    divisor,
   output logic                 done,
   output logic [TIME_W-1:0]    remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TIME_MS_W-1:0] num_ff, num_in;
   logic [TIME_W-1:0]    div_ff, div_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W:0]      trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[TIME_MS_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[TIME_MS_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = TIME_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[TIME_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(TIME_MS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/animation_frame_timeline_table_unit.sv -----
// Ordered frame table with cumulative end times. One transaction at a time: req_ready is
// high only while idle, and a result is held on rsp until taken. Entries live in
// single-port-read RAMs, so every entry moved or summed is a read, then a write.
// Append/insert shift later entries up and recompute all end times; delete shifts
// them down and recomputes; swap recomputes; replace and read do neither. Lookup
// runs the bit-serial remainder unit (one bit per cycle over 32 bits), then scans
// entries up to the hit. Errors go straight to the response state.
module animation_frame_timeline_table_unit
   import aftt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TIME_W-1:0]        total_ff, total_in;
   logic [TIME_W-1:0]        acc_ff, acc_in;
   entry_type                tmp_ff, tmp_in;
   status_type               status_ff, status_in;
   logic [IDX_W-1:0]         fidx_ff, fidx_in;
   logic [HANDLE_BITS-1:0]   fhnd_ff, fhnd_in;
   logic [DURATION_BITS-1:0] fdur_ff, fdur_in;
   logic [TIME_W-1:0]        fend_ff, fend_in;

   logic                     accept;
   logic [CNT_W-1:0]         ins_pos;
   logic                     ins_bad, full, pos_out, pos2_out, empty;
   logic [CNT_W-1:0]         idx_up, idx_dn;

   logic                     ent_wr_en;
   logic [IDX_W-1:0]         ent_wr_addr;
   entry_type                ent_wr_data;
   entry_type                ent_rd_data;
   logic                     end_wr_en;
   logic [TIME_W-1:0]        end_wr_data;
   logic [TIME_W-1:0]        end_rd_data;
   logic [IDX_W-1:0]         rd_addr;

   logic                     div_start;
   logic                     div_done;
   logic [TIME_W-1:0]        div_rem;

   assign accept   = req_valid && req_ready;
   assign ins_pos  = (req_data.opcode == OP_APPEND) ? count_ff : req_data.position;
   assign ins_bad  = ins_pos > count_ff;
   assign full     = count_ff >= CNT_W'(MAX_FRAMES);
   assign pos_out  = req_data.position >= count_ff;
   assign pos2_out = {1'b0, req_data.second_position} >= count_ff;
   assign empty    = count_ff == '0;
   assign idx_up   = idx_ff + 1'b1;
   assign idx_dn   = idx_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.opcode)
                  OP_APPEND, OP_INSERT: begin
                     if (ins_bad || full) begin
                        state_in = S_RSP;
                     end else if (ins_pos == count_ff) begin
                        state_in = S_INS_PUT;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_out) begin
                        state_in = S_RSP;
                     end else if ((req_data.position + 1'b1) < count_ff) begin
                        state_in = S_DEL_RD;
                     end else begin
                        state_in = S_DEL_FIN;
                     end
                  end
                  OP_REPLACE: state_in = pos_out ? S_RSP : S_REP_RD;
                  OP_SWAP:    state_in = (pos_out || pos2_out) ? S_RSP : S_SWP_RDA;
                  OP_LOOKUP: begin
                     if (empty) begin
                        state_in = S_RSP;
                     end else if (total_ff == '0) begin
                        state_in = S_EMT_RD;
                     end else begin
                        state_in = S_DIV_GO;
                     end
                  end
                  OP_READ: state_in = (empty || pos_out) ? S_RSP : S_EMT_RD;
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_INS_RD:  state_in = S_INS_WR;
         S_INS_WR:  state_in = (idx_dn == pos_ff) ? S_INS_PUT : S_INS_RD;
         S_INS_PUT: state_in = S_REC_GO;
         S_DEL_RD:  state_in = S_DEL_WR;
         S_DEL_WR:  state_in = ((idx_up + 1'b1) < count_ff) ? S_DEL_RD : S_DEL_FIN;
         S_DEL_FIN: state_in = S_REC_GO;
         S_REP_RD:  state_in = S_REP_WR;
         S_REP_WR:  state_in = S_RSP;
         S_SWP_RDA: state_in = S_SWP_RDB;
         S_SWP_RDB: state_in = S_SWP_WRA;
         S_SWP_WRA: state_in = S_SWP_WRB;
         S_SWP_WRB: state_in = S_REC_GO;
         S_REC_GO:  state_in = (count_ff == '0) ? S_RSP : S_REC_RD;
         S_REC_RD:  state_in = S_REC_WR;
         S_REC_WR:  state_in = (idx_up == count_ff) ? S_RSP : S_REC_RD;
         S_DIV_GO:  state_in = S_DIV_WAIT;
         S_DIV_WAIT: state_in = div_done ? S_SCN_RD : S_DIV_WAIT;
         S_SCN_RD:  state_in = S_SCN_CMP;
         S_SCN_CMP: state_in = (div_rem <= end_rd_data) ? S_RSP : S_SCN_RD;
         S_EMT_RD:  state_in = S_EMT_CAP;
         S_EMT_CAP: state_in = S_RSP;
         S_RSP:     state_in = rsp_ready ? S_IDLE : S_RSP;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in      = req_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      acc_in      = acc_ff;
      tmp_in      = tmp_ff;
      status_in   = status_ff;
      fidx_in     = fidx_ff;
      fhnd_in     = fhnd_ff;
      fdur_in     = fdur_ff;
      fend_in     = fend_ff;
      ent_wr_en   = 1'b0;
      ent_wr_addr = idx_ff[IDX_W-1:0];
      ent_wr_data = ent_rd_data;
      end_wr_en   = 1'b0;
      end_wr_data = acc_ff + TIME_W'(ent_rd_data.duration);
      rd_addr     = idx_ff[IDX_W-1:0];
      div_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               fidx_in = '0;
               fhnd_in = '0;
               fdur_in = '0;
               fend_in = '0;
               pos_in  = ins_pos;
               idx_in  = req_data.position;
               status_in = ST_OK;
               unique case (req_data.opcode)
                  OP_APPEND, OP_INSERT: begin
                     idx_in = count_ff;
                     priority if (ins_bad) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                     end
                  end
                  OP_DELETE, OP_REPLACE: begin
                     if (pos_out) begin
                        status_in = ST_RANGE;
                     end
                  end
                  OP_SWAP: begin
                     if (pos_out || pos2_out) begin
                        status_in = ST_RANGE;
                     end
                  end
                  OP_LOOKUP: begin
                     idx_in = '0;
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  OP_READ: begin
                     priority if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_out) begin
                        status_in = ST_RANGE;
                     end else begin
                        status_in = ST_OK;
                     end
                  end
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_INS_RD: rd_addr = idx_dn[IDX_W-1:0];
         S_INS_WR: begin
            ent_wr_en = 1'b1;
            idx_in    = idx_dn;
         end
         S_INS_PUT: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = pos_ff[IDX_W-1:0];
            ent_wr_data = '{handle: req_ff.frame_handle, duration: req_ff.duration_ms};
            count_in    = count_ff + 1'b1;
         end
         S_DEL_RD: rd_addr = idx_up[IDX_W-1:0];
         S_DEL_WR: begin
            ent_wr_en = 1'b1;
            idx_in    = idx_up;
         end
         S_DEL_FIN: count_in = count_ff - 1'b1;
         S_REP_RD: rd_addr = pos_ff[IDX_W-1:0];
         S_REP_WR: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = pos_ff[IDX_W-1:0];
            ent_wr_data = '{handle: req_ff.frame_handle, duration: ent_rd_data.duration};
         end
         S_SWP_RDA: rd_addr = pos_ff[IDX_W-1:0];
         S_SWP_RDB: begin
            rd_addr = req_ff.second_position;
            tmp_in  = ent_rd_data;
         end
         S_SWP_WRA: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = pos_ff[IDX_W-1:0];
         end
         S_SWP_WRB: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = req_ff.second_position;
            ent_wr_data = tmp_ff;
         end
         S_REC_GO: begin
            idx_in = '0;
            acc_in = '0;
            if (count_ff == '0) begin
               total_in = '0;
            end
         end
         S_REC_RD: rd_addr = idx_ff[IDX_W-1:0];
         S_REC_WR: begin
            end_wr_en = 1'b1;
            acc_in    = end_wr_data;
            idx_in    = idx_up;
            if (idx_up == count_ff) begin
               total_in = end_wr_data;
            end
         end
         S_DIV_GO: div_start = 1'b1;
         S_DIV_WAIT: idx_in = '0;
         S_SCN_RD: rd_addr = idx_ff[IDX_W-1:0];
         S_SCN_CMP: begin
            if (div_rem <= end_rd_data) begin
               fidx_in = idx_ff[IDX_W-1:0];
               fhnd_in = ent_rd_data.handle;
               fdur_in = ent_rd_data.duration;
               fend_in = end_rd_data;
            end else begin
               idx_in = idx_up;
            end
         end
         S_EMT_RD: rd_addr = idx_ff[IDX_W-1:0];
         S_EMT_CAP: begin
            fidx_in = idx_ff[IDX_W-1:0];
            fhnd_in = ent_rd_data.handle;
            fdur_in = ent_rd_data.duration;
            fend_in = end_rd_data;
         end
         S_RSP: status_in = status_ff;
         default: status_in = status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
      req_ff    <= req_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      fidx_ff   <= fidx_in;
      fhnd_ff   <= fhnd_in;
      fdur_ff   <= fdur_in;
      fend_ff   <= fend_in;
   end

   aftt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_FRAMES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ent_rd_data)
   );

   aftt_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_FRAMES)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (end_wr_en),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (end_wr_data),
      .rd_addr (rd_addr),
      .rd_data (end_rd_data)
   );

   aftt_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ff.time_ms),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RSP;

   assign rsp_data = '{
      status:           status_ff,
      found_index:      fidx_ff,
      out_frame_handle: fhnd_ff,
      out_duration_ms:  fdur_ff,
      end_time_ms:      fend_ff,
      entry_count:      count_ff,
      total_ms:         total_ff
   };

endmodule
